// ===== design/mmm_pkg.sv =====
// shared types and constants for the matrix multiply core
package mmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ACT_WRITE_A = 2'd0;
  localparam logic [1:0] ACT_WRITE_B = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  localparam logic [3:0] DIM_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_FEED,
    S_DRAIN,
    S_SHIFT
  } seq_state_t;

  typedef struct packed {
    logic clr;
    logic shift;
    logic emit;
    logic last;
  } seq_ctrl_t;

endpackage

// ===== design/mmm_cell.sv =====
// one column cell: holds a column of b, multiplies passing a words, accumulates
module mmm_cell #(
  parameter int MAX_DIM = mmm_pkg::MAX_DIM_DEF,
  parameter int IW      = $clog2(MAX_DIM),
  parameter int ACCW    = 64 + $clog2(MAX_DIM)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   b_we,
  input  logic [IW-1:0]          b_row,
  input  logic [31:0]            b_val,
  input  logic                   in_valid,
  input  logic [31:0]            in_a,
  input  logic [IW-1:0]          in_h,
  output logic                   out_valid,
  output logic [31:0]            out_a,
  output logic [IW-1:0]          out_h,
  input  mmm_pkg::seq_ctrl_t     ctrl,
  input  logic signed [ACCW-1:0] acc_in,
  output logic signed [ACCW-1:0] acc_out
);

  logic [31:0]            b_mem [MAX_DIM];
  logic [31:0]            b_rd_r;
  logic                   s1_valid_r;
  logic [31:0]            s1_a_r;
  logic [IW-1:0]          s1_h_r;
  logic                   p_valid_r;
  logic signed [63:0]     prod_r;
  logic signed [ACCW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_row] <= b_val;
    end
    b_rd_r <= b_mem[in_h];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      p_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r <= in_a;
    s1_h_r <= in_h;
    prod_r <= $signed(s1_a_r) * $signed(b_rd_r);
  end

  // shift moves finished sums toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.shift) begin
      acc_r <= acc_in;
    end else if (p_valid_r) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
  end

  assign out_valid = s1_valid_r;
  assign out_a     = s1_a_r;
  assign out_h     = s1_h_r;
  assign acc_out   = acc_r;

endmodule

// ===== design/mmm_seq.sv =====
// sequencer: holds matrix a, walks rows, feeds the cell chain and times the drain
module mmm_seq #(
  parameter int MAX_DIM = mmm_pkg::MAX_DIM_DEF,
  parameter int IW      = $clog2(MAX_DIM),
  parameter int DIMW    = $clog2(MAX_DIM + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         action,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic [31:0]        element_value,
  input  logic [DIMW-1:0]    dim_m,
  input  logic [DIMW-1:0]    dim_k,
  input  logic [DIMW-1:0]    dim_n,
  output logic               busy,
  output logic               a_valid,
  output logic [31:0]        a_data,
  output logic [IW-1:0]      a_h,
  output mmm_pkg::seq_ctrl_t ctrl,
  output logic [IW-1:0]      cur_row,
  output logic [IW-1:0]      cur_col
);

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int DRAIN_LEN = MAX_DIM + 3;
  localparam int CW        = $clog2(DRAIN_LEN);

  logic [31:0]         a_mem [DEPTH];
  mmm_pkg::seq_state_t state_r, state_nxt;
  logic [IW-1:0]       i_r, h_r, j_r;
  logic [CW-1:0]       cnt_r;
  logic                a_valid_r;
  logic [31:0]         a_data_r;
  logic [IW-1:0]       a_h_r;
  logic                wr_a;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                h_done, j_done, i_done, cnt_done;

  assign wr_a    = accept && action == mmm_pkg::ACT_WRITE_A
                   && int'(row_index) < MAX_DIM && int'(col_index) < MAX_DIM;
  assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));
  assign rd_addr = AW'(int'(i_r) * MAX_DIM + int'(h_r));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= element_value;
    end
    a_data_r <= a_mem[rd_addr];
    a_h_r    <= h_r;
  end

  assign h_done   = DIMW'(h_r) + DIMW'(1) == dim_k;
  assign j_done   = DIMW'(j_r) + DIMW'(1) == dim_n;
  assign i_done   = DIMW'(i_r) + DIMW'(1) == dim_m;
  assign cnt_done = cnt_r == CW'(DRAIN_LEN - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmm_pkg::S_IDLE: begin
        if (accept && action == mmm_pkg::ACT_COMPUTE && dim_m != '0 && dim_n != '0) begin
          state_nxt = mmm_pkg::S_CLR;
        end
      end
      mmm_pkg::S_CLR: begin
        state_nxt = (dim_k == '0) ? mmm_pkg::S_DRAIN : mmm_pkg::S_FEED;
      end
      mmm_pkg::S_FEED: begin
        if (h_done) state_nxt = mmm_pkg::S_DRAIN;
      end
      mmm_pkg::S_DRAIN: begin
        if (cnt_done) state_nxt = mmm_pkg::S_SHIFT;
      end
      mmm_pkg::S_SHIFT: begin
        if (j_done) state_nxt = i_done ? mmm_pkg::S_IDLE : mmm_pkg::S_CLR;
      end
      default: state_nxt = mmm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mmm_pkg::S_IDLE;
      a_valid_r <= 1'b0;
      i_r       <= '0;
      h_r       <= '0;
      j_r       <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      a_valid_r <= state_r == mmm_pkg::S_FEED;
      case (state_r)
        mmm_pkg::S_IDLE: begin
          i_r <= '0;
        end
        mmm_pkg::S_CLR: begin
          h_r   <= '0;
          cnt_r <= '0;
        end
        mmm_pkg::S_FEED: begin
          h_r <= h_r + IW'(1);
        end
        mmm_pkg::S_DRAIN: begin
          cnt_r <= cnt_r + CW'(1);
          j_r   <= '0;
        end
        mmm_pkg::S_SHIFT: begin
          j_r <= j_r + IW'(1);
          if (j_done) i_r <= i_r + IW'(1);
        end
        default: begin
          i_r <= '0;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.clr   = state_r == mmm_pkg::S_CLR;
    ctrl.shift = state_r == mmm_pkg::S_SHIFT;
    ctrl.emit  = state_r == mmm_pkg::S_SHIFT;
    ctrl.last  = state_r == mmm_pkg::S_SHIFT && j_done && i_done;
  end

  assign busy    = state_r != mmm_pkg::S_IDLE;
  assign a_valid = a_valid_r;
  assign a_data  = a_data_r;
  assign a_h     = a_h_r;
  assign cur_row = i_r;
  assign cur_col = j_r;

endmodule

// ===== design/matrix_matrix_multiply_core.sv =====
// top level of the fixed-point matrix multiply core: config, cell chain, output stage
// Element writes (actions 0 and 1) give no result. A compute holds busy high while
// it runs, each size capped at MAX_DIM, and its last result word leaves in the
// first cycle with busy low; with zero rows or columns it gives no result and busy
// stays low. Per row of the result there is a clear state, a feed of inner_dim row
// elements of A from its memory into a chain of MAX_DIM column cells, a drain
// through the cell pipelines, and a shift of the finished sums out of the chain, one
// result word per cycle. Each result is shown for exactly one cycle on out_valid and
// must be taken then; the receiver cannot stall.
module matrix_matrix_multiply_core #(
  parameter int MAX_DIM   = mmm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mmm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_row_index,
  input  logic [2:0]  in_col_index,
  input  logic [31:0] in_element_value,
  output logic        out_valid,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic [31:0] out_product_value,
  output logic        out_saturated,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int IW   = $clog2(MAX_DIM);
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int ACCW = 64 + $clog2(MAX_DIM);

  logic [3:0]         rows_r, inner_r, cols_r;
  logic [DIMW-1:0]    dim_m, dim_k, dim_n;
  logic               accept;
  logic               wr_b;
  mmm_pkg::seq_ctrl_t ctrl;
  logic [IW-1:0]      cur_row, cur_col;

  logic                   lnk_valid [MAX_DIM+1];
  logic [31:0]            lnk_a     [MAX_DIM+1];
  logic [IW-1:0]          lnk_h     [MAX_DIM+1];
  logic signed [ACCW-1:0] acc       [MAX_DIM+1];

  logic signed [ACCW-1:0] shifted;
  logic                   fits;

  logic        out_valid_r;
  logic [2:0]  out_row_r, out_col_r;
  logic [31:0] out_val_r;
  logic        out_sat_r, out_last_r;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mmm_pkg::DIM_RESET;
      inner_r <= mmm_pkg::DIM_RESET;
      cols_r  <= mmm_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmm_pkg::CFG_ROWS_A:    rows_r  <= cfg_data;
        mmm_pkg::CFG_INNER_DIM: inner_r <= cfg_data;
        mmm_pkg::CFG_COLS_B:    cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // dimensions above the built-in maximum act as the maximum
  assign dim_m = (int'(rows_r)  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(rows_r);
  assign dim_k = (int'(inner_r) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(inner_r);
  assign dim_n = (int'(cols_r)  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(cols_r);

  assign wr_b = accept && in_action == mmm_pkg::ACT_WRITE_B
                && int'(in_row_index) < MAX_DIM && int'(in_col_index) < MAX_DIM;

  mmm_seq #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW),
    .DIMW    (DIMW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .action        (in_action),
    .row_index     (in_row_index),
    .col_index     (in_col_index),
    .element_value (in_element_value),
    .dim_m         (dim_m),
    .dim_k         (dim_k),
    .dim_n         (dim_n),
    .busy          (busy),
    .a_valid       (lnk_valid[0]),
    .a_data        (lnk_a[0]),
    .a_h           (lnk_h[0]),
    .ctrl          (ctrl),
    .cur_row       (cur_row),
    .cur_col       (cur_col)
  );

  assign acc[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    mmm_cell #(
      .MAX_DIM (MAX_DIM),
      .IW      (IW),
      .ACCW    (ACCW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .b_we      (wr_b && int'(in_col_index) == g),
      .b_row     (IW'(in_row_index)),
      .b_val     (in_element_value),
      .in_valid  (lnk_valid[g]),
      .in_a      (lnk_a[g]),
      .in_h      (lnk_h[g]),
      .out_valid (lnk_valid[g+1]),
      .out_a     (lnk_a[g+1]),
      .out_h     (lnk_h[g+1]),
      .ctrl      (ctrl),
      .acc_in    (acc[g+1]),
      .acc_out   (acc[g])
    );
  end

  // the word leaving cell zero is scaled and clipped to 32 bits
  assign shifted = acc[0] >>> FRAC_BITS;
  assign fits    = (&shifted[ACCW-1:31]) || !(|shifted[ACCW-1:31]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= 3'(cur_row);
    out_col_r  <= 3'(cur_col);
    out_last_r <= ctrl.last;
    out_sat_r  <= !fits;
    if (fits) begin
      out_val_r <= shifted[31:0];
    end else begin
      out_val_r <= shifted[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_val_r;
  assign out_saturated     = out_sat_r;
  assign out_last          = out_last_r;

endmodule

// ===== design/mmm_checker.sv =====
// port-level checks for the matrix multiply core, bound to the top level
module mmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_last,
  input logic       out_saturated,
  input logic [31:0] out_product_value
);

  // a word that is not the last of a run leaves while the run still holds busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("result word before the last one seen while not busy");

  // the last word of a run leaves as the core goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("core still busy when the last word leaves");

  // busy starts only from an accepted command
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // a clipped word carries one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_product_value == 32'h8000_0000 || out_product_value == 32'h7FFF_FFFF))
    else $error("saturated word does not hold a limit value");

endmodule

bind matrix_matrix_multiply_core mmm_checker u_mmm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_last          (out_last),
  .out_saturated     (out_saturated),
  .out_product_value (out_product_value)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the fixed-point matrix multiply core
`timescale 1ns / 100ps

class product_scoreboard;
  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        sat;
    logic        last;
  } entry_t;

  logic [31:0] a_mem[64];
  logic [31:0] b_mem[64];
  logic [3:0]  dims[3];
  entry_t      pending[$];
  int          errors;
  int          matched;
  int          computes;

  function new();
    dims[0] = mmm_pkg::DIM_RESET;
    dims[1] = mmm_pkg::DIM_RESET;
    dims[2] = mmm_pkg::DIM_RESET;
    errors = 0;
    matched = 0;
    computes = 0;
  endfunction

  function void set_dim(logic [1:0] idx, logic [3:0] val);
    dims[idx] = val;
  endfunction

  function int clamp(logic [3:0] d);
    return (d > 8) ? 8 : int'(d);
  endfunction

  // exact wide sum, arithmetic shift, then clip to 32 bits
  function void predict_product();
    int m, k, n, total, cnt;
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    longint p;
    entry_t e;
    m = clamp(dims[mmm_pkg::CFG_ROWS_A]);
    k = clamp(dims[mmm_pkg::CFG_INNER_DIM]);
    n = clamp(dims[mmm_pkg::CFG_COLS_B]);
    total = m * n;
    cnt = 0;
    computes++;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int h = 0; h < k; h++) begin
          p = longint'($signed(a_mem[i*8+h])) * longint'($signed(b_mem[h*8+j]));
          acc = acc + p;
        end
        sh = acc >>> mmm_pkg::FRAC_BITS_DEF;
        e.row = i[2:0];
        e.col = j[2:0];
        if (sh > 128'sd2147483647) begin
          e.value = 32'h7fffffff;
          e.sat = 1'b1;
        end else if (sh < -128'sd2147483648) begin
          e.value = 32'h80000000;
          e.sat = 1'b1;
        end else begin
          e.value = sh[31:0];
          e.sat = 1'b0;
        end
        cnt++;
        e.last = (cnt == total);
        pending.push_back(e);
      end
    end
  endfunction

  function void note_input(logic [1:0] act, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    case (act)
      mmm_pkg::ACT_WRITE_A: a_mem[{r, c}] = v;
      mmm_pkg::ACT_WRITE_B: b_mem[{r, c}] = v;
      mmm_pkg::ACT_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic [2:0] r, logic [2:0] c, logic [31:0] v, logic s, logic l);
    entry_t e;
    if (pending.size() == 0) begin
      report("unexpected word, row", r, 0);
      return;
    end
    e = pending.pop_front();
    if (r !== e.row) report("row", r, e.row);
    if (c !== e.col) report("col", c, e.col);
    if (v !== e.value) report("product", v, e.value);
    if (s !== e.sat) report("saturated", s, e.sat);
    if (l !== e.last) report("last", l, e.last);
    matched++;
  endtask
endclass

module testbench;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [2:0]  in_row_index;
  logic [2:0]  in_col_index;
  logic [31:0] in_element_value;
  logic        out_valid;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] out_product_value;
  logic        out_saturated;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  product_scoreboard sb;
  int          random_items;

  matrix_matrix_multiply_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_row, out_col, out_product_value, out_saturated, out_last);
  end

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic send_word(logic [1:0] act, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_row_index <= r;
    in_col_index <= c;
    in_element_value <= v;
    do @(posedge clk); while (busy);
    sb.note_input(act, r, c, v);
  endtask

  // let every expected word arrive, then allow the pipeline to settle
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_dim(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_dim(idx, val);
  endtask

  task automatic set_shape(logic [3:0] m, logic [3:0] k, logic [3:0] n);
    write_dim(mmm_pkg::CFG_ROWS_A, m);
    write_dim(mmm_pkg::CFG_INNER_DIM, k);
    write_dim(mmm_pkg::CFG_COLS_B, n);
  endtask

  task automatic run_product();
    send_word(mmm_pkg::ACT_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
    drain_results();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_action = mmm_pkg::ACT_WRITE_A;
    in_row_index = '0;
    in_col_index = '0;
    in_element_value = '0;
    cfg_valid = 1'b0;
    cfg_index = mmm_pkg::CFG_ROWS_A;
    cfg_data = '0;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both stores so no compute reads an unwritten element
    for (int i = 0; i < 64; i++) begin
      send_word(mmm_pkg::ACT_WRITE_A, i[5:3], i[2:0], pick_element());
      send_word(mmm_pkg::ACT_WRITE_B, i[5:3], i[2:0], pick_element());
    end

    // extremes: positive and negative clipping, unused action
    send_word(mmm_pkg::ACT_WRITE_A, 3'd0, 3'd0, 32'h7fffffff);
    send_word(mmm_pkg::ACT_WRITE_A, 3'd0, 3'd1, 32'h7fffffff);
    send_word(mmm_pkg::ACT_WRITE_B, 3'd0, 3'd0, 32'h7fffffff);
    send_word(mmm_pkg::ACT_WRITE_B, 3'd1, 3'd0, 32'h7fffffff);
    send_word(mmm_pkg::ACT_WRITE_B, 3'd0, 3'd7, 32'h80000000);
    send_word(mmm_pkg::ACT_WRITE_B, 3'd1, 3'd7, 32'h80000000);
    send_word(mmm_pkg::ACT_WRITE_A, 3'd7, 3'd7, 32'h00000000);
    send_word(mmm_pkg::ACT_NONE, 3'd7, 3'd7, 32'hffffffff);
    run_product();
    set_shape(4'd1, 4'd1, 4'd1);
    run_product();
    set_shape(4'd0, 4'd8, 4'd8);
    run_product();
    set_shape(4'd8, 4'd8, 4'd0);
    run_product();
    set_shape(4'd3, 4'd0, 4'd5);
    run_product();
    set_shape(4'd15, 4'd15, 4'd15);
    run_product();
    set_shape(4'd8, 4'd2, 4'd8);
    run_product();

    // random phases: a new shape, a few element updates, then a compute
    while (random_items < 60) begin
      set_shape(($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8)),
                ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8)),
                ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8)));
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 15) == 0)
          send_word(mmm_pkg::ACT_NONE, 3'($urandom()), 3'($urandom()), $urandom());
        else
          send_word($urandom_range(0, 1) ? mmm_pkg::ACT_WRITE_B : mmm_pkg::ACT_WRITE_A,
                    3'($urandom()), 3'($urandom()), pick_element());
        random_items++;
      end
      run_product();
      random_items++;
    end

    drain_results();
    $display("ran %0d products, %0d result words checked", sb.computes, sb.matched);
    $display("shapes covered empty, zero-inner, clamped and full sizes with clipping");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
